/* hdl/tdpe_pkg.sv */
// shared types and constants for the thumb data-processing execute block
// no dependencies
package tdpe_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned RegIdxW = 4;

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_PRELOAD_REG = 2'd1,
    KIND_PRELOAD_FLAGS = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] opcode;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [3:0]  flags_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        unsupported;
  } out_item_t;
endpackage

/* hdl/tdpe_if.sv */
// valid/ready channel carrying one payload beat
// payload type is given by the payload_t parameter
interface tdpe_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/thumb_data_processing_execute.sv */
// thumb data-processing execute stage with register file and nzcv flags
// depends on tdpe_pkg and tdpe_if
//
// usage: items arrive on the in channel (kind, opcode, preload fields);
// each accepted beat yields exactly one result beat on the out channel
// with the register written, its value, the flags after the item and an
// unsupported mark.
// the result is registered and valid in the cycle after input acceptance.
// throughput: one item per cycle while out is not stalled; the register file and flags are updated
// in the same cycle as the item is accepted, so the next item sees them.
// the whole decode, shifter, adder and 32x32 multiply sit between the
// state registers and the output register.
// reset: synchronous rst clears all sixteen registers, the flags and the
// output valid.
// stall: when out.ready is low the result register holds; in.ready drops
// only while a result is held and not being taken.
module thumb_data_processing_execute (
  input logic clk,
  input logic rst,
  tdpe_if.sink   in,
  tdpe_if.source out
);
  import tdpe_pkg::*;

  logic [DataW-1:0] regs [NumRegs];
  logic [3:0] flags;
  logic out_valid;
  out_item_t out_data;

  logic take;
  assign in.ready = !out_valid || out.ready;
  assign take = in.valid && in.ready;
  assign out.valid = out_valid;
  assign out.data = out_data;

  in_item_t it;
  assign it = in.data;

  // combinational execute
  logic [3:0]  dst;
  logic        wr;
  logic [31:0] res;
  logic [3:0]  fl_next;
  logic        unsup;

  logic [15:0] op;
  logic [31:0] a, b, sh_v;
  logic [32:0] sum;
  logic        do_add, set_nzf, set_cv;
  logic [31:0] add_a, add_b;
  logic        add_cin;
  logic [1:0]  sh_kind;
  logic [7:0]  sh_amt;
  logic [31:0] sh_res;
  logic        sh_c;
  logic [31:0] prod;
  logic [2:0]  rd3, rs3;
  logic [3:0]  hrd, hrs;

  always_comb begin
    op = it.opcode;
    rd3 = op[2:0];
    rs3 = op[5:3];
    hrd = {op[7], op[2:0]};
    hrs = {op[6], op[5:3]};
    a = regs[{1'b0, rs3}];
    b = regs[{1'b0, rd3}];
    // shifter operand selection
    sh_v = regs[{1'b0, rs3}];
    sh_kind = op[12:11];
    sh_amt = (op[10:6] == 5'd0) ? 8'd32 : {3'd0, op[10:6]};
    if (op[15:12] == 4'd4) begin
      sh_v = regs[{1'b0, rd3}];
      sh_amt = regs[{1'b0, rs3}][7:0];
      unique case (op[9:6])
        4'd2: sh_kind = 2'd0;
        4'd3: sh_kind = 2'd1;
        4'd4: sh_kind = 2'd2;
        default: sh_kind = 2'd3;
      endcase
    end
    sh_res = sh_v;
    sh_c = flags[1];
    if (sh_amt != 8'd0) begin
      case (sh_kind)
        2'd0: begin
          if (sh_amt < 8'd32) begin
            sh_res = sh_v << sh_amt[4:0];
            // bit 32 - amt, taken modulo 32
            sh_c = sh_v[5'd0 - sh_amt[4:0]];
          end else begin
            sh_res = '0;
            sh_c = (sh_amt == 8'd32) ? sh_v[0] : 1'b0;
          end
        end
        2'd1: begin
          if (sh_amt < 8'd32) begin
            sh_res = sh_v >> sh_amt[4:0];
            sh_c = sh_v[sh_amt[4:0] - 5'd1];
          end else begin
            sh_res = '0;
            sh_c = (sh_amt == 8'd32) ? sh_v[31] : 1'b0;
          end
        end
        2'd2: begin
          if (sh_amt < 8'd32) begin
            sh_res = 32'($signed(sh_v) >>> sh_amt[4:0]);
            sh_c = sh_v[sh_amt[4:0] - 5'd1];
          end else begin
            sh_res = {32{sh_v[31]}};
            sh_c = sh_v[31];
          end
        end
        default: begin
          if (sh_amt[4:0] == 5'd0) begin
            sh_c = sh_v[31];
          end else begin
            sh_res = (sh_v >> sh_amt[4:0]) | (sh_v << (6'd32 - {1'b0, sh_amt[4:0]}));
            sh_c = sh_v[sh_amt[4:0] - 5'd1];
          end
        end
      endcase
    end
    prod = regs[{1'b0, rd3}] * regs[{1'b0, rs3}];

    add_a = '0; add_b = '0; add_cin = 1'b0;
    do_add = 1'b0; set_nzf = 1'b0; set_cv = 1'b0;
    dst = '0; wr = 1'b0; res = '0; unsup = 1'b0;
    fl_next = flags;

    unique case (kind_t'(it.kind))
      KIND_PRELOAD_REG: begin
        dst = it.reg_index; wr = 1'b1; res = it.reg_value;
      end
      KIND_PRELOAD_FLAGS: fl_next = it.flags_value;
      KIND_RSVD: unsup = 1'b1;
      default: begin
        if (op[15:13] == 3'd0) begin
          dst = {1'b0, rd3}; wr = 1'b1;
          if (op[12:11] == 2'b11) begin
            add_a = a;
            add_b = op[10] ? {29'd0, op[8:6]} : regs[{1'b0, op[8:6]}];
            if (op[9]) begin add_b = ~add_b; add_cin = 1'b1; end
            do_add = 1'b1; set_cv = 1'b1;
          end else begin
            if (op[12:11] == 2'd0 && op[10:6] == 5'd0) res = a;
            else begin res = sh_res; fl_next[1] = sh_c; end
            set_nzf = 1'b1;
          end
        end else if (op[15:13] == 3'd1) begin
          add_a = regs[{1'b0, op[10:8]}];
          add_b = {24'd0, op[7:0]};
          dst = {1'b0, op[10:8]};
          case (op[12:11])
            2'd0: begin res = add_b; set_nzf = 1'b1; wr = 1'b1; end
            2'd1: begin add_b = ~add_b; add_cin = 1'b1; do_add = 1'b1; set_cv = 1'b1; end
            2'd2: begin do_add = 1'b1; set_cv = 1'b1; wr = 1'b1; end
            default: begin
              add_b = ~add_b; add_cin = 1'b1; do_add = 1'b1; set_cv = 1'b1; wr = 1'b1;
            end
          endcase
        end else if (op[15:10] == 6'b010000) begin
          dst = {1'b0, rd3}; wr = 1'b1; set_nzf = 1'b1;
          add_a = b; add_b = a;
          case (op[9:6])
            4'd0: res = b & a;
            4'd1: res = b ^ a;
            4'd2, 4'd3, 4'd4, 4'd7: begin res = sh_res; fl_next[1] = sh_c; end
            4'd5: begin do_add = 1'b1; set_cv = 1'b1; add_cin = flags[1]; end
            4'd6: begin
              add_b = ~a; do_add = 1'b1; set_cv = 1'b1; add_cin = flags[1];
            end
            4'd8: begin res = b & a; wr = 1'b0; end
            4'd9: begin
              add_a = '0; add_b = ~a; add_cin = 1'b1; do_add = 1'b1; set_cv = 1'b1;
            end
            4'd10: begin
              add_b = ~a; add_cin = 1'b1; do_add = 1'b1; set_cv = 1'b1; wr = 1'b0;
            end
            4'd11: begin do_add = 1'b1; set_cv = 1'b1; wr = 1'b0; end
            4'd12: res = b | a;
            4'd13: begin res = prod; fl_next[1] = 1'b0; end
            4'd14: res = b & ~a;
            default: res = ~a;
          endcase
        end else if (op[15:10] == 6'b010001) begin
          add_a = regs[hrd]; add_b = regs[hrs];
          case (op[9:8])
            2'd0: begin dst = hrd; wr = 1'b1; res = add_a + add_b; end
            2'd1: begin add_b = ~add_b; add_cin = 1'b1; do_add = 1'b1; set_cv = 1'b1; end
            2'd2: begin dst = hrd; wr = 1'b1; res = add_b; end
            default: unsup = 1'b1;
          endcase
        end else begin
          unsup = 1'b1;
        end
      end
    endcase

    sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    if (do_add) begin
      res = sum[31:0];
      set_nzf = 1'b1;
    end
    if (set_cv) begin
      fl_next[1] = sum[32];
      fl_next[0] = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]);
    end
    if (set_nzf) begin
      fl_next[3] = res[31];
      fl_next[2] = (res == 32'd0);
    end
    if (unsup) begin
      wr = 1'b0; fl_next = flags;
    end
    if (!wr) begin
      dst = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{default: '0};
      flags <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        if (wr) regs[dst] <= res;
        flags <= fl_next;
        out_valid <= 1'b1;
        out_data.dest_index <= dst;
        out_data.dest_value <= wr ? res : 32'd0;
        out_data.dest_written <= wr;
        out_data.flag_n <= fl_next[3];
        out_data.flag_z <= fl_next[2];
        out_data.flag_c <= fl_next[1];
        out_data.flag_v <= fl_next[0];
        out_data.unsupported <= unsup;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_unsup_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.unsupported |-> !out_data.dest_written)
    else $error("unsupported item wrote a register");
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dest_written |-> out_data.dest_value == 32'd0)
    else $error("value reported without a write");
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    $past(take) && !$past(rst) |->
    {out_data.flag_n, out_data.flag_z, out_data.flag_c, out_data.flag_v} == flags)
    else $error("reported flags differ from state");
`endif
endmodule
